// File: rtl/ega_pkg.sv
// shared constants and types for the embedding gradient accumulator
package ega_pkg;

    // default table geometry
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_MAX_COLUMNS = 64;

    // field widths
    localparam int ROW_W   = 10;
    localparam int COL_W   = 6;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int ROWS_W  = 11;
    localparam int COLS_W  = 7;
    localparam int CFG_W   = 11;
    localparam int IN_W    = ROW_W + COL_W + VAL_W;
    localparam int OUT_W   = 40;
    localparam int OUT_PAD = OUT_W - VAL_W - STAT_W;

    // register indexes
    localparam logic REG_ROWS_IN_USE    = 1'b0;
    localparam logic REG_COLUMNS_IN_USE = 1'b1;

    // register reset values
    localparam logic [ROWS_W-1:0] RESET_ROWS = 11'd1024;
    localparam logic [COLS_W-1:0] RESET_COLS = 7'd64;

    // commands
    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ_CLEAR = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

endpackage

// File: rtl/ega_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module ega_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents when the same entry is written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/embedding_gradient_accumulator_core.sv
// embedding gradient scatter-add store: range check, read-modify-write, output word
// path: stage 1 holds a taken word while the ram is read, then its result waits in the output register
// throughput: one word per cycle outside zeroing and result stalls, via forwarded write-back
// reset: registers return to full size; the table is then zeroed one entry a cycle,
// all MAX_ROWS * MAX_COLUMNS entries (65536 by default), with no input word taken meanwhile
// configuration writes are taken at any time, also during the zeroing sweep
module embedding_gradient_accumulator_core #(
    parameter int MAX_ROWS    = ega_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = ega_pkg::DEF_MAX_COLUMNS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [ega_pkg::CFG_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [ega_pkg::IN_W-1:0]    i_s_tdata,  // row[9:0], column[15:10], grad_value[47:16]
    input  logic                        i_s_tuser,  // cmd
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [ega_pkg::OUT_W-1:0]   o_m_tdata   // read_value[31:0], status[33:32], zero pad
);

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    // configuration registers
    logic [ega_pkg::ROWS_W-1:0] r_rows_in_use;
    logic [ega_pkg::COLS_W-1:0] r_cols_in_use;

    // zeroing sweep
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // stage 1: ram data arrives
    logic                      r_s1_valid;
    logic                      r_s1_cmd;
    logic                      r_s1_in_range;
    logic [AW-1:0]             r_s1_addr;
    logic [ega_pkg::VAL_W-1:0] r_s1_grad;

    // last write-back, for an item whose read overlapped it
    logic                      r_fwd_valid;
    logic [AW-1:0]             r_fwd_addr;
    logic [ega_pkg::VAL_W-1:0] r_fwd_data;

    // output register
    logic                      r_out_valid;
    logic [ega_pkg::VAL_W-1:0] r_out_value;
    ega_pkg::t_status          r_out_status;

    logic [ega_pkg::ROW_W-1:0] in_row;
    logic [ega_pkg::COL_W-1:0] in_col;
    logic [ega_pkg::VAL_W-1:0] in_grad;
    logic                      in_range;
    logic [AW-1:0]             in_addr;
    logic                      accept;
    logic                      s1_adv;

    logic [ega_pkg::VAL_W-1:0] ram_rdata;
    logic [ega_pkg::VAL_W-1:0] old_value;
    logic [ega_pkg::VAL_W:0]   sum;
    logic                      overflow;
    logic [ega_pkg::VAL_W-1:0] new_value;
    ega_pkg::t_status          s1_status;
    logic [ega_pkg::VAL_W-1:0] s1_read_value;

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [ega_pkg::VAL_W-1:0] wr_data;

    assign in_row  = i_s_tdata[ega_pkg::ROW_W-1:0];
    assign in_col  = i_s_tdata[ega_pkg::ROW_W+ega_pkg::COL_W-1:ega_pkg::ROW_W];
    assign in_grad = i_s_tdata[ega_pkg::IN_W-1:ega_pkg::ROW_W+ega_pkg::COL_W];

    assign in_range = ({1'b0, in_row} < r_rows_in_use) && (32'(in_row) < 32'(MAX_ROWS)) &&
                      ({1'b0, in_col} < r_cols_in_use) && (32'(in_col) < 32'(MAX_COLUMNS));

    // row-major with a fixed stride; only meaningful when in range
    assign in_addr = AW'(32'(in_row) * 32'(MAX_COLUMNS) + 32'(in_col));

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_clearing && (!r_s1_valid || s1_adv);
    assign accept     = i_s_tvalid && o_s_tready;

    ega_ram #(
        .WIDTH (ega_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // modify
    always_comb begin
        old_value = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : ram_rdata;
        sum       = {old_value[ega_pkg::VAL_W-1], old_value} +
                    {r_s1_grad[ega_pkg::VAL_W-1], r_s1_grad};
        overflow  = sum[ega_pkg::VAL_W] != sum[ega_pkg::VAL_W-1];
        if (overflow) begin
            new_value = sum[ega_pkg::VAL_W] ? ega_pkg::Q_MIN : ega_pkg::Q_MAX;
        end else begin
            new_value = sum[ega_pkg::VAL_W-1:0];
        end

        s1_status     = ega_pkg::ST_OK;
        s1_read_value = '0;
        if (!r_s1_in_range) begin
            s1_status = ega_pkg::ST_RANGE;
        end else if (r_s1_cmd == ega_pkg::CMD_READ_CLEAR) begin
            s1_read_value = old_value;
        end else if (overflow) begin
            s1_status = ega_pkg::ST_SATURATED;
        end
    end

    // write-back, or the zeroing sweep
    always_comb begin
        wr_en   = r_clearing || (s1_adv && r_s1_in_range);
        wr_addr = r_clearing ? r_clr_addr : r_s1_addr;
        if (r_clearing || (r_s1_cmd == ega_pkg::CMD_READ_CLEAR)) begin
            wr_data = '0;
        end else begin
            wr_data = new_value;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ega_pkg::RESET_ROWS;
            r_cols_in_use <= ega_pkg::RESET_COLS;
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_s1_valid    <= 1'b0;
            r_fwd_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ega_pkg::REG_ROWS_IN_USE:    r_rows_in_use <= i_cfg_wdata;
                    ega_pkg::REG_COLUMNS_IN_USE:
                        r_cols_in_use <= i_cfg_wdata[ega_pkg::COLS_W-1:0];
                    default: ;
                endcase
            end

            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv && r_s1_in_range) begin
                r_fwd_valid <= 1'b1;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd      <= i_s_tuser;
            r_s1_in_range <= in_range;
            r_s1_addr     <= in_addr;
            r_s1_grad     <= in_grad;
        end
        if (s1_adv && r_s1_in_range) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= wr_data;
        end
        if (s1_adv) begin
            r_out_value  <= s1_read_value;
            r_out_status <= s1_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{ega_pkg::OUT_PAD{1'b0}}, r_out_status, r_out_value};

endmodule

// File: tb/tb_embedding_gradient_accumulator_core.sv
// testbench for the embedding gradient scatter-add store: directed and random words, self-checking
module tb_embedding_gradient_accumulator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ega_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int LONG_HOLD      = 80;
    localparam int NUM_PHASES     = 8;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        t_status          status;
    } grad_result_t;

    class grad_store_scoreboard;
        bit [VAL_W-1:0] entries [DEF_MAX_ROWS*DEF_MAX_COLUMNS];
        int unsigned    rows_lim;
        int unsigned    cols_lim;
        grad_result_t   pending [$];
        int             errors;
        int             words_in;
        int             words_out;
        int             saturations;
        int             range_hits;
        int             reads;

        function new();
            rows_lim = 32'(RESET_ROWS);
            cols_lim = 32'(RESET_COLS);
        endfunction

        function void set_reg(logic idx, int unsigned val);
            if (idx == REG_ROWS_IN_USE)
                rows_lim = val;
            else
                cols_lim = val;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // work out the result of one accepted word and update the shadow table
        function void note_word(logic cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                logic [VAL_W-1:0] grad);
            grad_result_t     exp;
            logic signed [VAL_W:0] sum;
            int unsigned      addr;
            int unsigned      rmax;
            int unsigned      cmax;
            rmax = (rows_lim < DEF_MAX_ROWS) ? rows_lim : DEF_MAX_ROWS;
            cmax = (cols_lim < DEF_MAX_COLUMNS) ? cols_lim : DEF_MAX_COLUMNS;
            exp.value  = '0;
            exp.status = ST_OK;
            words_in++;
            if (row >= rmax || col >= cmax) begin
                exp.status = ST_RANGE;
                range_hits++;
            end else begin
                addr = row * DEF_MAX_COLUMNS + col;
                if (cmd == CMD_READ_CLEAR) begin
                    exp.value     = entries[addr];
                    entries[addr] = '0;
                    reads++;
                end else begin
                    sum = $signed({entries[addr][VAL_W-1], entries[addr]})
                        + $signed({grad[VAL_W-1], grad});
                    if (sum[VAL_W] != sum[VAL_W-1]) begin
                        exp.status    = ST_SATURATED;
                        entries[addr] = sum[VAL_W] ? Q_MIN : Q_MAX;
                        saturations++;
                    end else begin
                        entries[addr] = sum[VAL_W-1:0];
                    end
                end
            end
            pending.push_back(exp);
        endfunction

        function void check_word(logic [VAL_W-1:0] value, logic [STAT_W-1:0] status);
            grad_result_t exp;
            words_out++;
            if (pending.size() == 0) begin
                $display("%0t: result word with nothing expected: value %h status %0d",
                         $time, value, status);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (value !== exp.value) begin
                $display("%0t: read_value mismatch: expected %h actual %h",
                         $time, exp.value, value);
                errors++;
            end
            if (status !== exp.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic                 i_cfg_index = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata   = '0;  // row[9:0], column[15:10], grad_value[47:16]
    logic                 i_s_tuser   = 1'b0; // cmd
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;          // read_value[31:0], status[33:32], zero pad

    grad_store_scoreboard sb = new();

    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;
    int          hold_req      = 0;
    int          hold_done     = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    int unsigned cur_rows      = 32'(RESET_ROWS);
    int unsigned cur_cols      = 32'(RESET_COLS);

    embedding_gradient_accumulator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off when asked for
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done = hold_done + 1;
            hold_left = LONG_HOLD - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_word(o_m_tdata[VAL_W-1:0], o_m_tdata[VAL_W+STAT_W-1:VAL_W]);
    end

    // no word moving on either side for too long means the block is stuck
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, sb.outstanding());
            $display("tb_embedding_gradient_accumulator_core: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_ROWS_IN_USE)
            cur_rows = val;
        else
            cur_cols = val;
        sb.set_reg(idx, val);
    endtask

    task automatic set_sizes(int unsigned rows, int unsigned cols);
        write_reg(REG_ROWS_IN_USE, rows);
        write_reg(REG_COLUMNS_IN_USE, cols);
    endtask

    task automatic send_word(logic cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                             logic [VAL_W-1:0] grad);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {grad, col, row};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_word(cmd, row, col, grad);
    endtask

    // stop offering and let every expected result come back
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_index(int unsigned lim, int unsigned width_max);
        int unsigned hot;
        int unsigned sel;
        int unsigned idx;
        sel = $urandom_range(0, 99);
        if (lim > width_max)
            lim = width_max;
        if (lim == 0 || sel >= 90) begin
            idx = $urandom_range(0, width_max - 1);
        end else if (sel >= 80) begin
            // right on the edge of the configured size
            idx = (lim < width_max) ? lim : lim - 1;
        end else begin
            // a few hot entries at each end so sums pile up and saturate
            hot = (lim < 4) ? lim : 4;
            idx = $urandom_range(0, hot - 1) + ($urandom_range(0, 1) ? lim - hot : 0);
        end
        return idx;
    endfunction

    function automatic logic [VAL_W-1:0] pick_grad();
        int unsigned sel;
        logic [VAL_W-1:0] mag;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
        end else if (sel < 70) begin
            mag = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
            return $urandom_range(0, 1) ? mag : -mag;
        end
        return $urandom;
    endfunction

    task automatic send_random();
        logic cmd;
        cmd = ($urandom_range(0, 99) < 30) ? CMD_READ_CLEAR : CMD_ACCUMULATE;
        send_word(cmd, ROW_W'(pick_index(cur_rows, DEF_MAX_ROWS)),
                  COL_W'(pick_index(cur_cols, DEF_MAX_COLUMNS)), pick_grad());
    endtask

    int unsigned phase_rows  [NUM_PHASES] = '{1024, 1, 1024, 37, 2047, 1024, 0, 500};
    int unsigned phase_cols  [NUM_PHASES] = '{64, 1, 64, 9, 127, 64, 0, 40};
    int          phase_words [NUM_PHASES] = '{250, 100, 250, 250, 200, 250, 50, 150};

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full size: extremes, saturation both ways, read and clear
        set_sizes(1024, 64);
        send_word(CMD_ACCUMULATE, 10'd1023, 6'd63, 32'h7FFF_FFFF);
        send_word(CMD_ACCUMULATE, 10'd1023, 6'd63, 32'h0000_0001);
        send_word(CMD_READ_CLEAR, 10'd1023, 6'd63, 32'hFFFF_FFFF);
        send_word(CMD_READ_CLEAR, 10'd1023, 6'd63, 32'h0);
        send_word(CMD_ACCUMULATE, 10'd0, 6'd0, 32'h8000_0000);
        send_word(CMD_ACCUMULATE, 10'd0, 6'd0, 32'hFFFF_FFFF);
        send_word(CMD_READ_CLEAR, 10'd0, 6'd0, 32'h0);
        send_word(CMD_ACCUMULATE, 10'd5, 6'd7, 32'h0001_0000);
        send_word(CMD_ACCUMULATE, 10'd5, 6'd7, 32'hFFFF_8000);
        send_word(CMD_READ_CLEAR, 10'd5, 6'd7, 32'h0);
        send_word(CMD_ACCUMULATE, 10'd682, 6'd42, 32'h5555_5555);
        send_word(CMD_ACCUMULATE, 10'd341, 6'd21, 32'hAAAA_AAAA);
        send_word(CMD_READ_CLEAR, 10'd682, 6'd42, 32'h0);
        send_word(CMD_READ_CLEAR, 10'd341, 6'd21, 32'h0);
        drain();

        // small table: row and column each just past the end
        set_sizes(3, 2);
        send_word(CMD_ACCUMULATE, 10'd3, 6'd0, 32'h0000_0100);
        send_word(CMD_ACCUMULATE, 10'd0, 6'd2, 32'h0000_0100);
        send_word(CMD_READ_CLEAR, 10'd3, 6'd1, 32'h0);
        send_word(CMD_ACCUMULATE, 10'd2, 6'd1, 32'h1234_5678);
        send_word(CMD_READ_CLEAR, 10'd2, 6'd1, 32'h0);
        drain();

        // zero size rejects everything
        set_sizes(0, 0);
        send_word(CMD_ACCUMULATE, 10'd0, 6'd0, 32'h0000_0001);
        send_word(CMD_READ_CLEAR, 10'd0, 6'd0, 32'h0);
        drain();

        // sizes above the table are limited by the table itself
        set_sizes(2047, 127);
        send_word(CMD_ACCUMULATE, 10'd1023, 6'd63, 32'h0000_0042);
        send_word(CMD_READ_CLEAR, 10'd1023, 6'd63, 32'h0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_sizes(phase_rows[p], phase_cols[p]);
            case (p % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 48;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 48;
                end
                default: begin
                    src_idle_pct   = 20;
                    sink_stall_pct = 20;
                end
            endcase
            for (int n = 0; n < phase_words[p]; n++) begin
                // back-pressure: result side holds off while words keep coming
                if (p == 0 && n == 60)
                    hold_req = hold_req + 1;
                // sender waits mid-stream for the block to empty
                if (p == 2 && n == 120)
                    drain();
                send_random();
            end
            drain();
        end

        if (sb.outstanding() != 0)
            sb.errors++;
        $display("covered %0d words, %0d results: %0d reads, %0d saturated, %0d out of range",
                 sb.words_in, sb.words_out, sb.reads, sb.saturations, sb.range_hits);
        $display("sizes from zero to above the table, four idling mixes, one long result stall");
        if (sb.errors == 0) begin
            $display("tb_embedding_gradient_accumulator_core: done, clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("tb_embedding_gradient_accumulator_core: done, errors");
        end
        $finish;
    end

endmodule

// File: embedding_gradient_accumulator_core.f
rtl/ega_pkg.sv
rtl/ega_ram.sv
rtl/embedding_gradient_accumulator_core.sv
tb/tb_embedding_gradient_accumulator_core.sv
